### src/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

   // Header length codes in the 7-bit length field
   localparam logic [6:0] LEN16_CODE = 7'd126;
   localparam logic [6:0] LEN64_CODE = 7'd127;

   // Extension byte counts
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_RSV     = 2'd1;
   localparam logic [1:0] STATUS_UNMASK  = 2'd2;
   localparam logic [1:0] STATUS_LEN_TOP = 2'd3;

   // Queue between the parser and the output stage
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Parser phases
   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   // One classified result waiting for the output stage
   typedef struct packed {
      logic [7:0] data;
      logic [7:0] key;
      logic       present;
      logic       frame_end;
      logic [3:0] opcode;
      logic       fin;
      logic [1:0] status;
   } entry_type;

endpackage

### src/wsd_front.sv
// Frame header parser: classifies each received byte and queues results.
module wsd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_in_byte,
   input  logic                q_full,
   output logic                q_push,
   output wsd_pkg::entry_type  q_entry
);
   import wsd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [4:0]  fin_op_ff, fin_op_in;
   logic [3:0]  ext_left_ff, ext_left_in;
   logic [63:0] remain_ff, remain_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  key_idx_ff, key_idx_in;
   logic        halted_ff, halted_in;
   logic        accept;
   logic [7:0]  b;
   logic [1:0]  idx_next;
   logic [7:0]  key_byte;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_in_byte;
   assign idx_next  = key_idx_ff + 2'd1;

   // Key byte for the current payload position, first key byte first
   always_comb begin
      case (key_idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Parser state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR0;
         fin_op_ff   <= '0;
         ext_left_ff <= '0;
         remain_ff   <= '0;
         key_ff      <= '0;
         key_idx_ff  <= '0;
         halted_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         fin_op_ff   <= fin_op_in;
         ext_left_ff <= ext_left_in;
         remain_ff   <= remain_in;
         key_ff      <= key_in;
         key_idx_ff  <= key_idx_in;
         halted_ff   <= halted_in;
      end
   end

   // Next state and result classification
   always_comb begin
      phase_in          = phase_ff;
      fin_op_in         = fin_op_ff;
      ext_left_in       = ext_left_ff;
      remain_in         = remain_ff;
      key_in            = key_ff;
      key_idx_in        = key_idx_ff;
      halted_in         = halted_ff;
      q_push            = 1'b0;
      q_entry.data      = 8'd0;
      q_entry.key       = 8'd0;
      q_entry.present   = 1'b0;
      q_entry.frame_end = 1'b1;
      q_entry.opcode    = fin_op_ff[3:0];
      q_entry.fin       = fin_op_ff[4];
      q_entry.status    = STATUS_OK;

      if (accept && !halted_ff) begin
         unique case (phase_ff)
            PH_HDR0: begin
               fin_op_in = {b[7], b[3:0]};
               phase_in  = PH_HDR1;
               q_entry.opcode = b[3:0];
               q_entry.fin    = b[7];
               if (b[6:4] != 3'd0) begin
                  halted_in      = 1'b1;
                  q_push         = 1'b1;
                  q_entry.status = STATUS_RSV;
               end
            end
            PH_HDR1: begin
               if (!b[7]) begin
                  halted_in      = 1'b1;
                  q_push         = 1'b1;
                  q_entry.status = STATUS_UNMASK;
               end else begin
                  remain_in  = '0;
                  key_in     = '0;
                  key_idx_in = '0;
                  if (b[6:0] == LEN16_CODE) begin
                     ext_left_in = EXT16_BYTES;
                     phase_in    = PH_EXT;
                  end else if (b[6:0] == LEN64_CODE) begin
                     ext_left_in = EXT64_BYTES;
                     phase_in    = PH_EXT;
                  end else begin
                     remain_in   = {57'd0, b[6:0]};
                     ext_left_in = '0;
                     phase_in    = PH_KEY;
                  end
               end
            end
            PH_EXT: begin
               if (ext_left_ff == EXT64_BYTES && b[7]) begin
                  halted_in      = 1'b1;
                  q_push         = 1'b1;
                  q_entry.status = STATUS_LEN_TOP;
               end else begin
                  remain_in = {remain_ff[55:0], b};
                  if (ext_left_ff != 4'd0) begin
                     ext_left_in = ext_left_ff - 4'd1;
                  end
                  if (ext_left_ff <= 4'd1) begin
                     phase_in = PH_KEY;
                  end
               end
            end
            PH_KEY: begin
               key_in     = {key_ff[23:0], b};
               key_idx_in = idx_next;
               if (idx_next == 2'd0) begin
                  if (remain_ff == 64'd0) begin
                     phase_in = PH_HDR0;
                     q_push   = 1'b1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               key_idx_in = idx_next;
               if (remain_ff != 64'd0) begin
                  remain_in = remain_ff - 64'd1;
               end
               q_push            = 1'b1;
               q_entry.data      = b;
               q_entry.key       = key_byte;
               q_entry.present   = 1'b1;
               q_entry.frame_end = (remain_ff <= 64'd1);
               if (remain_ff <= 64'd1) begin
                  phase_in   = PH_HDR0;
                  key_idx_in = '0;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase
      end
   end

endmodule

### src/wsd_queue.sv
// Short result queue between the parser and the output stage.
module wsd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wsd_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output wsd_pkg::entry_type  head
);
   import wsd_pkg::*;

   entry_type          slots_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = slots_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### src/wsd_back.sv
// Output stage: unmasks queued bytes into the result register.
module wsd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_not_empty,
   input  wsd_pkg::entry_type  q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_byte_present,
   output logic                rsp_frame_end,
   output logic [3:0]          rsp_frame_opcode,
   output logic                rsp_final_fragment,
   output logic [1:0]          rsp_status
);
   import wsd_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       present_ff;
   logic       end_ff;
   logic [3:0] opcode_ff;
   logic       fin_ff;
   logic [1:0] status_ff;

   // Load a new beat when the register is empty or being drained
   assign q_pop    = q_not_empty && (!valid_ff || rsp_ready);
   assign valid_in = q_pop || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result payload, XOR with the key byte on load
   always_ff @(posedge clock) begin
      if (q_pop) begin
         byte_ff    <= q_head.data ^ q_head.key;
         present_ff <= q_head.present;
         end_ff     <= q_head.frame_end;
         opcode_ff  <= q_head.opcode;
         fin_ff     <= q_head.fin;
         status_ff  <= q_head.status;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_byte_present   = present_ff;
   assign rsp_frame_end      = end_ff;
   assign rsp_frame_opcode   = opcode_ff;
   assign rsp_final_fragment = fin_ff;
   assign rsp_status         = status_ff;

endmodule

### src/websocket_frame_deframer.sv
// WebSocket client frame deframer: parser, result queue and output stage.
//
// Usage: received frame bytes enter on the req_ channel, one byte per beat.
// Header, extended length and masking key bytes give no result. Each payload
// byte gives one result beat on the rsp_ channel with the unmasked byte,
// byte_present set and frame_end set on the frame's last byte. A zero-length
// frame gives one empty beat with frame_end set after its last key byte.
// A reserved bit, a missing mask bit or a 64-bit length with its top bit set
// gives one error beat (nonzero status, frame_end set); after it every
// input byte is taken and dropped until reset.
// Throughput: one byte per cycle in both directions while the queue has room
// and rsp_ready is high; the output stage drains one queue entry a cycle.
// Path: with the queue empty, an accepted byte's result is written into the
// queue, then loaded into the output register that drives rsp_.
// Stall: when rsp_ready is low, results collect in a four-entry queue and
// the output register; req_ready drops only once the queue is full.
// Reset (synchronous, active high) returns the parser to the first header
// byte, clears the halt and empties the queue and output register.
module websocket_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_present,
   output logic       rsp_frame_end,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_final_fragment,
   output logic [1:0] rsp_status
);
   import wsd_pkg::*;

   entry_type push_entry;
   entry_type head;
   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_not_empty;

   wsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (push_entry)
   );

   wsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (head)
   );

   wsd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_head             (head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_present   (rsp_byte_present),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_final_fragment (rsp_final_fragment),
      .rsp_status         (rsp_status)
   );

endmodule

### src/wsd_checker.sv
// Port-level checker for the deframer and its bind to the top level.
module wsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_present,
   input logic       rsp_frame_end,
   input logic [3:0] rsp_frame_opcode,
   input logic       rsp_final_fragment,
   input logic [1:0] rsp_status
);
   import wsd_pkg::*;

   // A stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_status) && $stable(rsp_frame_end) && $stable(rsp_byte_present)
         && $stable(rsp_frame_opcode) && $stable(rsp_final_fragment))
      else $error("stalled result beat changed");

   // A beat without a payload byte carries zero and closes a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_present |-> rsp_out_byte == 8'd0 && rsp_frame_end)
      else $error("empty beat malformed");

   // Error beats close the frame and carry no byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_frame_end && !rsp_byte_present)
      else $error("error beat malformed");

   // Reset empties the output register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_out_byte       (rsp_out_byte),
   .rsp_byte_present   (rsp_byte_present),
   .rsp_frame_end      (rsp_frame_end),
   .rsp_frame_opcode   (rsp_frame_opcode),
   .rsp_final_fragment (rsp_final_fragment),
   .rsp_status         (rsp_status)
);

### bench/websocket_frame_deframer_tb.sv
// Testbench for the WebSocket frame deframer: frame stimulus, unmask predictor, beat checker.
module websocket_frame_deframer_tb;
   import wsd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_BYTES = 1750;
   localparam int STEADY_BYTES = 160;
   localparam int DRAIN_CYCLES = 16;
   localparam int IDLE_PCT = 24;

   typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       present;
      logic       frame_end;
      logic [3:0] opcode;
      logic       fin;
      logic [1:0] status;
   } deframed_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_present;
   logic       rsp_frame_end;
   logic [3:0] rsp_frame_opcode;
   logic       rsp_final_fragment;
   logic [1:0] rsp_status;

   websocket_frame_deframer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_present   (rsp_byte_present),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_final_fragment (rsp_final_fragment),
      .rsp_status         (rsp_status)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted parser state
   phase_type   parse_at = PH_HDR0;
   logic        hdr_fin = 1'b0;
   logic [3:0]  hdr_opcode = 4'h0;
   logic [3:0]  ext_left = 4'h0;
   logic [63:0] bytes_left = 64'h0;
   logic [31:0] mask_key = 32'h0;
   logic [1:0]  key_pos = 2'h0;
   logic        stream_halted = 1'b0;

   deframed_beat_type pending_results[$];

   int  cycles = 0;
   int  errors = 0;
   int  bytes_sent = 0;
   int  frames_sent = 0;
   int  beats_checked = 0;
   bit  steady = 1'b0;
   string closing_error = "none";

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycles,
                  pending_results.size());
         $display("websocket_frame_deframer regression: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 40) $display("mismatch @cycle %0d: %s", cycles, msg);
   endtask

   function automatic void queue_result(input logic [7:0] data, input logic present,
                                        input logic last, input logic [1:0] status);
      deframed_beat_type beat;
      beat.out_byte = data;
      beat.present = present;
      beat.frame_end = last;
      beat.opcode = hdr_opcode;
      beat.fin = hdr_fin;
      beat.status = status;
      pending_results.push_back(beat);
   endfunction

   function automatic void halt_with(input logic [1:0] status);
      stream_halted = 1'b1;
      queue_result(8'h00, 1'b0, 1'b1, status);
   endfunction

   // Advance the predicted parser by one accepted byte
   function automatic void deframe_byte(input logic [7:0] b);
      logic [7:0] key_byte;
      logic       last;
      if (stream_halted) return;
      case (parse_at)
         PH_HDR0: begin
            hdr_fin = b[7];
            hdr_opcode = b[3:0];
            parse_at = PH_HDR1;
            if (b[6:4] != 3'b000) halt_with(STATUS_RSV);
         end
         PH_HDR1: begin
            if (!b[7]) begin
               halt_with(STATUS_UNMASK);
            end else begin
               bytes_left = 64'h0;
               mask_key = 32'h0;
               key_pos = 2'h0;
               if (b[6:0] == LEN16_CODE) begin
                  ext_left = EXT16_BYTES;
                  parse_at = PH_EXT;
               end else if (b[6:0] == LEN64_CODE) begin
                  ext_left = EXT64_BYTES;
                  parse_at = PH_EXT;
               end else begin
                  bytes_left = {57'h0, b[6:0]};
                  ext_left = 4'h0;
                  parse_at = PH_KEY;
               end
            end
         end
         PH_EXT: begin
            // only the leading byte of a 64-bit length is checked for its top bit
            if (ext_left == EXT64_BYTES && b[7]) begin
               halt_with(STATUS_LEN_TOP);
            end else begin
               bytes_left = {bytes_left[55:0], b};
               if (ext_left != 4'h0) ext_left = ext_left - 4'h1;
               if (ext_left == 4'h0) parse_at = PH_KEY;
            end
         end
         PH_KEY: begin
            mask_key = {mask_key[23:0], b};
            key_pos = key_pos + 2'h1;
            if (key_pos == 2'h0) begin
               if (bytes_left == 64'h0) begin
                  parse_at = PH_HDR0;
                  queue_result(8'h00, 1'b0, 1'b1, STATUS_OK);
               end else begin
                  parse_at = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            key_byte = mask_key[8 * (3 - int'(key_pos)) +: 8];
            key_pos = key_pos + 2'h1;
            if (bytes_left != 64'h0) bytes_left = bytes_left - 64'h1;
            last = (bytes_left == 64'h0);
            if (last) begin
               parse_at = PH_HDR0;
               key_pos = 2'h0;
            end
            queue_result(b ^ key_byte, 1'b1, last, STATUS_OK);
         end
         default: parse_at = PH_HDR0;
      endcase
   endfunction

   // One byte beat on the request side; valid stays up across back-to-back beats
   task automatic send_byte(input logic [7:0] b);
      if (!steady) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      deframe_byte(b);
   endtask

   // Whole masked frame; fill < 0 gives random payload bytes
   task automatic send_frame(input logic fin, input logic [3:0] opcode, input int unsigned len,
                             input len_form_type form, input logic [31:0] key, input int fill);
      logic [63:0] len_bits;
      len_bits = 64'(len);
      send_byte({fin, 3'b000, opcode});
      case (form)
         FORM_EXT16: begin
            send_byte({1'b1, LEN16_CODE});
            send_byte(len_bits[15:8]);
            send_byte(len_bits[7:0]);
         end
         FORM_EXT64: begin
            send_byte({1'b1, LEN64_CODE});
            for (int i = 7; i >= 0; i--) send_byte(len_bits[8 * i +: 8]);
         end
         default: send_byte({1'b1, len_bits[6:0]});
      endcase
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
      for (int unsigned i = 0; i < len; i++)
         send_byte((fill < 0) ? 8'($urandom) : 8'(fill));
      frames_sent++;
   endtask

   task automatic send_random_frame();
      int           pick;
      int unsigned  len;
      len_form_type form;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         form = FORM_SHORT;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
      end else if (pick < 88) begin
         form = FORM_EXT16;
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(126, 400) : $urandom_range(0, 20);
      end else begin
         form = FORM_EXT64;
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 16);
      end
      send_frame(1'($urandom), 4'($urandom), len, form, $urandom, -1);
   endtask

   // Length encodings and field extremes
   task automatic test_directed_frames();
      send_frame(1'b1, 4'h0, 0, FORM_SHORT, 32'h0000_0000, -1);
      send_frame(1'b0, 4'hF, 1, FORM_SHORT, 32'hFFFF_FFFF, 8'hFF);
      send_frame(1'b1, 4'h8, 5, FORM_EXT16, 32'hA5C3_0F81, 8'h00);
      send_frame(1'b1, 4'h2, 2, FORM_EXT64, 32'h0102_0408, -1);
      send_frame(1'b0, 4'h9, 0, FORM_EXT16, 32'hFFFF_FFFF, -1);
   endtask

   task automatic test_random_frames();
      int start;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) send_random_frame();
   endtask

   // Long stretch without idling on either side
   task automatic test_steady_stream();
      int start;
      start = bytes_sent;
      steady <= 1'b1;
      while (bytes_sent - start < STEADY_BYTES) send_random_frame();
      steady <= 1'b0;
   endtask

   // One protocol error ends the stream; later bytes must be swallowed
   task automatic test_protocol_error();
      logic [1:0] kind;
      logic [7:0] hdr;
      kind = 2'($urandom_range(STATUS_RSV, STATUS_LEN_TOP));
      hdr = {1'($urandom), 3'b000, 4'($urandom)};
      case (kind)
         STATUS_RSV: begin
            closing_error = "reserved bits";
            hdr[6:4] = 3'($urandom_range(1, 7));
            send_byte(hdr);
         end
         STATUS_UNMASK: begin
            closing_error = "unmasked frame";
            send_byte(hdr);
            send_byte({1'b0, 7'($urandom)});
         end
         default: begin
            closing_error = "64-bit length top bit";
            send_byte(hdr);
            send_byte({1'b1, LEN64_CODE});
            send_byte(8'($urandom_range(128, 255)));
         end
      endcase
      repeat (24) send_byte(8'($urandom));
   endtask

   // Result side: check each accepted beat, then pick the next ready level
   always @(posedge clock) begin
      deframed_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected beat, byte %h end %b status %0d",
                                         rsp_out_byte, rsp_frame_end, rsp_status));
            end else begin
               want = pending_results.pop_front();
               beats_checked++;
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %h, want %h", rsp_out_byte, want.out_byte));
               if (rsp_byte_present !== want.present)
                  report_mismatch($sformatf("byte_present %b, want %b", rsp_byte_present,
                                            want.present));
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch($sformatf("frame_end %b, want %b", rsp_frame_end,
                                            want.frame_end));
               if (rsp_frame_opcode !== want.opcode)
                  report_mismatch($sformatf("frame_opcode %h, want %h", rsp_frame_opcode,
                                            want.opcode));
               if (rsp_final_fragment !== want.fin)
                  report_mismatch($sformatf("final_fragment %b, want %b", rsp_final_fragment,
                                            want.fin));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            end
         end
         rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_random_frames();
      test_steady_stream();
      test_protocol_error();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d frames in %0d request bytes, %0d result beats checked",
               frames_sent, bytes_sent, beats_checked);
      $display("stream closed by a %s error, %0d mismatches", closing_error, errors);
      if (errors == 0)
         $display("websocket_frame_deframer regression: pass");
      else
         $display("websocket_frame_deframer regression: fail");
      $finish;
   end

endmodule
